@@ rtl/dhp_pkg.sv @@
package dhp_pkg;

    // Field and register widths fixed by the interface.
    localparam int FS_W       = 24;
    localparam int DIM_REG_W  = 11;
    localparam int COORD_W    = 10;
    localparam int ADDR_W     = 20;
    localparam int CHAN_W     = 8;
    localparam int COLOUR_W   = 3 * CHAN_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Output stream data: colour in the low bits, then the address, padded to bytes.
    localparam int OUT_DATA_W = ((COLOUR_W + ADDR_W + 7) / 8) * 8;

    // Largest frame dimension that the address arithmetic supports.
    localparam int MAX_DIM = 1024;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);

    // Scale position: unsigned fixed point with ten fractional bits.
    localparam int LEVEL_FRAC = 10;
    localparam int LEVEL_W    = LEVEL_FRAC + 1;
    localparam int LEVEL_TOP  = 1 << LEVEL_FRAC;

    // Heat scale segments and the position within one segment.
    localparam int SEG_LSB  = 8;
    localparam int SEG_SPAN = 1 << SEG_LSB;
    localparam int FRAC_W   = SEG_LSB + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    // Register values after reset.
    localparam logic [FS_W-1:0]      RST_FULL_SCALE   = 24'd65536;
    localparam logic [DIM_REG_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [DIM_REG_W-1:0] RST_FRAME_HEIGHT = 11'd1024;

    typedef enum logic [1:0] {
        SEG_BLUE,
        SEG_CYAN,
        SEG_YELLOW,
        SEG_RED
    } t_seg;

endpackage

@@ rtl/dhp_isqrt.sv @@
module dhp_isqrt #(
    parameter int W     = 24,
    parameter int TAG_W = 21
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [2*W-1:0]   i_radicand,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_vld,
    output logic [W-1:0]     o_root,
    output logic [TAG_W-1:0] o_tag
);

    // One root bit is settled per stage, most significant first.
    localparam int RW = 2 * W;

    logic             r_vld [W];
    logic [RW-1:0]    r_rem [W];
    logic [RW-1:0]    r_res [W];
    logic [TAG_W-1:0] r_tag [W];

    genvar s;
    generate
        for (s = 0; s < W; s++) begin : g_stage
            localparam logic [RW-1:0] BIT = RW'(1) << (2 * (W - 1 - s));

            logic             vld_in;
            logic [RW-1:0]    rem_in;
            logic [RW-1:0]    res_in;
            logic [TAG_W-1:0] tag_in;
            logic [RW-1:0]    trial;
            logic             take;
            logic [RW-1:0]    n_rem;
            logic [RW-1:0]    n_res;

            if (s == 0) begin : g_first
                assign vld_in = i_vld;
                assign rem_in = i_radicand;
                assign res_in = '0;
                assign tag_in = i_tag;
            end else begin : g_next
                assign vld_in = r_vld[s-1];
                assign rem_in = r_rem[s-1];
                assign res_in = r_res[s-1];
                assign tag_in = r_tag[s-1];
            end

            // Subtract the trial term when it fits and set this root bit.
            always_comb begin
                trial = res_in + BIT;
                take  = (rem_in >= trial);
                n_rem = take ? (rem_in - trial) : rem_in;
                n_res = take ? ((res_in >> 1) + BIT) : (res_in >> 1);
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (i_en) begin
                    r_vld[s] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                    r_res[s] <= n_res;
                    r_tag[s] <= tag_in;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[W-1];
    assign o_root = r_res[W-1][W-1:0];
    assign o_tag  = r_tag[W-1];

endmodule

@@ rtl/dhp_scale.sv @@
module dhp_scale #(
    parameter int MAG_W = 24,
    parameter int TAG_W = 21
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [MAG_W-1:0]            i_mag,
    input  logic [dhp_pkg::FS_W-1:0]    i_full_scale,
    input  logic [TAG_W-1:0]            i_tag,
    output logic                        o_vld,
    output logic [dhp_pkg::LEVEL_W-1:0] o_level,
    output logic [TAG_W-1:0]            o_tag
);

    import dhp_pkg::*;

    // Stage zero checks for saturation; each later stage yields one quotient bit.
    localparam int CMP_W  = (MAG_W > FS_W) ? MAG_W : FS_W;
    localparam int NSTAGE = LEVEL_FRAC + 1;

    logic                  r_vld [NSTAGE];
    logic                  r_sat [NSTAGE];
    logic [FS_W-1:0]       r_rem [NSTAGE];
    logic [LEVEL_FRAC-1:0] r_q   [NSTAGE];
    logic [TAG_W-1:0]      r_tag [NSTAGE];

    genvar s;
    generate
        for (s = 0; s < NSTAGE; s++) begin : g_stage
            logic                  vld_in;
            logic [TAG_W-1:0]      tag_in;
            logic                  n_sat;
            logic [FS_W-1:0]       n_rem;
            logic [LEVEL_FRAC-1:0] n_q;

            if (s == 0) begin : g_first
                // A magnitude at or above full scale pins the level to the top.
                assign vld_in = i_vld;
                assign tag_in = i_tag;
                always_comb begin
                    n_sat = (CMP_W'(i_mag) >= CMP_W'(i_full_scale));
                    n_rem = FS_W'(i_mag);
                    n_q   = '0;
                end
            end else begin : g_next
                logic          sat_in;
                logic [FS_W:0] dbl;
                logic          take;

                assign vld_in = r_vld[s-1];
                assign sat_in = r_sat[s-1];
                assign tag_in = r_tag[s-1];

                // Restoring division step on a remainder kept below full scale.
                always_comb begin
                    dbl   = {r_rem[s-1], 1'b0};
                    take  = (dbl >= {1'b0, i_full_scale});
                    n_sat = sat_in;
                    n_rem = take ? FS_W'(dbl - {1'b0, i_full_scale}) : FS_W'(dbl);
                    n_q   = {r_q[s-1][LEVEL_FRAC-2:0], take};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (i_en) begin
                    r_vld[s] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sat[s] <= n_sat;
                    r_rem[s] <= n_rem;
                    r_q[s]   <= n_q;
                    r_tag[s] <= tag_in;
                end
            end
        end
    endgenerate

    assign o_vld   = r_vld[NSTAGE-1];
    assign o_level = r_sat[NSTAGE-1] ? LEVEL_W'(LEVEL_TOP) : {1'b0, r_q[NSTAGE-1]};
    assign o_tag   = r_tag[NSTAGE-1];

endmodule

@@ rtl/displacement_heatmap_pixel.sv @@
// Pipeline: three entry stages, one square root stage per magnitude bit, eleven scaling stages,
// one output stage. Throughput: one item per cycle while the output is not stalled; an input skid
// register takes one more item while the output stalls. Reset (synchronous, active low) empties
// the pipeline and the skid register and loads full_scale = 65536, frame_width = 1024 and
// frame_height = 1024.
module displacement_heatmap_pixel #(
    parameter int SAMPLE_BITS = 24,
    localparam int IN_W = ((2 * SAMPLE_BITS + 2 * dhp_pkg::COORD_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input items.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // From bit 0: horiz_disp, vert_disp, column, row, zero padding.
    input  logic [IN_W-1:0]                s_axis_tdata,
    // Result items.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // From bit 0: pixel_colour, pixel_address, zero padding.
    output logic [dhp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Bit 0: coordinate_error.
    output logic                           m_axis_tuser,
    // Configuration writes.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dhp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dhp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import dhp_pkg::*;

    localparam int SB         = SAMPLE_BITS;
    localparam int SQ_W       = 2 * SB;
    localparam int TAG_W      = ADDR_W + 1;
    localparam int ADDR_SUM_W = (2 * DIM_W > ADDR_W) ? 2 * DIM_W : ADDR_W;

    // Configuration registers.
    logic [FS_W-1:0]      r_full_scale;
    logic [DIM_REG_W-1:0] r_frame_width;
    logic [DIM_REG_W-1:0] r_frame_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale   <= RST_FULL_SCALE;
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_FULL_SCALE) begin
                r_full_scale <= i_cfg_data[FS_W-1:0];
            end
            if (i_cfg_index == CFG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data[DIM_REG_W-1:0];
            end
            if (i_cfg_index == CFG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg_data[DIM_REG_W-1:0];
            end
        end
    end

    // Effective settings: zero full scale acts as one, dimensions clamp to the maximum.
    logic [FS_W-1:0]  fs_eff;
    logic [DIM_W-1:0] dim_w;
    logic [DIM_W-1:0] dim_h;

    always_comb begin
        fs_eff = (r_full_scale == '0) ? FS_W'(1) : r_full_scale;
        dim_w  = (int'(r_frame_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_frame_width);
        dim_h  = (int'(r_frame_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_frame_height);
    end

    // The whole pipeline moves unless the output register holds an untaken item.
    logic r_o_vld;
    logic en;

    assign en = !r_o_vld || m_axis_tready;

    // Input skid register catches one item that arrives while the pipeline is held.
    logic            r_skid_vld;
    logic [IN_W-1:0] r_skid_data;
    logic            in_acc;
    logic            front_vld;
    logic [IN_W-1:0] front_data;

    assign s_axis_tready = !r_skid_vld;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign front_vld     = r_skid_vld || in_acc;
    assign front_data    = r_skid_vld ? r_skid_data : s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (en) begin
            r_skid_vld <= 1'b0;
        end else if (in_acc) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && in_acc) begin
            r_skid_data <= s_axis_tdata;
        end
    end

    // Stage A: absolute values, range check and flipped row.
    logic [SB-1:0]      horiz;
    logic [SB-1:0]      vert;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [SB-1:0]      habs;
    logic [SB-1:0]      vabs;
    logic               coord_err;
    logic [DIM_W-1:0]   flip_row;

    always_comb begin
        horiz     = front_data[SB-1:0];
        vert      = front_data[2*SB-1:SB];
        col       = front_data[2*SB +: COORD_W];
        row       = front_data[2*SB+COORD_W +: COORD_W];
        habs      = horiz[SB-1] ? (SB'(~horiz) + SB'(1)) : horiz;
        vabs      = vert[SB-1] ? (SB'(~vert) + SB'(1)) : vert;
        coord_err = (int'(col) >= int'(dim_w)) || (int'(row) >= int'(dim_h));
        flip_row  = DIM_W'(dim_h - DIM_W'(row) - DIM_W'(1));
    end

    logic               r_a_vld;
    logic [SB-1:0]      r_a_habs;
    logic [SB-1:0]      r_a_vabs;
    logic               r_a_err;
    logic [DIM_W-1:0]   r_a_row;
    logic [DIM_W-1:0]   r_a_w;
    logic [COORD_W-1:0] r_a_col;

    // Stage B: squares and the frame address.
    logic [SQ_W-1:0]       hsq;
    logic [SQ_W-1:0]       vsq;
    logic [ADDR_SUM_W-1:0] addr_sum;

    always_comb begin
        hsq      = r_a_habs * r_a_habs;
        vsq      = r_a_vabs * r_a_vabs;
        addr_sum = ADDR_SUM_W'(r_a_row) * ADDR_SUM_W'(r_a_w) + ADDR_SUM_W'(r_a_col);
    end

    logic              r_b_vld;
    logic [SQ_W-1:0]   r_b_hsq;
    logic [SQ_W-1:0]   r_b_vsq;
    logic [ADDR_W-1:0] r_b_addr;
    logic              r_b_err;

    // Stage C: sum of squares.
    logic              r_c_vld;
    logic [SQ_W-1:0]   r_c_sum;
    logic [ADDR_W-1:0] r_c_addr;
    logic              r_c_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= front_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_habs <= habs;
            r_a_vabs <= vabs;
            r_a_err  <= coord_err;
            r_a_row  <= flip_row;
            r_a_w    <= dim_w;
            r_a_col  <= col;

            r_b_hsq  <= hsq;
            r_b_vsq  <= vsq;
            r_b_addr <= r_a_err ? '0 : addr_sum[ADDR_W-1:0];
            r_b_err  <= r_a_err;

            r_c_sum  <= r_b_hsq + r_b_vsq;
            r_c_addr <= r_b_addr;
            r_c_err  <= r_b_err;
        end
    end

    // Magnitude by pipelined integer square root.
    logic             sq_vld;
    logic [SB-1:0]    sq_root;
    logic [TAG_W-1:0] sq_tag;

    dhp_isqrt #(
        .W     (SB),
        .TAG_W (TAG_W)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (r_c_vld),
        .i_radicand (r_c_sum),
        .i_tag      ({r_c_addr, r_c_err}),
        .o_vld      (sq_vld),
        .o_root     (sq_root),
        .o_tag      (sq_tag)
    );

    // Normalization to the scale position against full scale.
    logic               sc_vld;
    logic [LEVEL_W-1:0] sc_level;
    logic [TAG_W-1:0]   sc_tag;

    dhp_scale #(
        .MAG_W (SB),
        .TAG_W (TAG_W)
    ) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_vld        (sq_vld),
        .i_mag        (sq_root),
        .i_full_scale (fs_eff),
        .i_tag        (sq_tag),
        .o_vld        (sc_vld),
        .o_level      (sc_level),
        .o_tag        (sc_tag)
    );

    // Heat scale: pick the segment, then ramp one or two channels up or down within it.
    t_seg              seg;
    logic [FRAC_W-1:0] frac;
    logic [FRAC_W-1:0] inv;
    logic [16:0]       up_prod;
    logic [16:0]       down_prod;
    logic [CHAN_W-1:0] up;
    logic [CHAN_W-1:0] down;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    always_comb begin
        seg       = sc_level[LEVEL_W-1] ? SEG_RED : t_seg'(sc_level[SEG_LSB +: 2]);
        frac      = FRAC_W'(sc_level - (LEVEL_W'(seg) << SEG_LSB));
        inv       = FRAC_W'(SEG_SPAN) - frac;
        up_prod   = {frac, 8'h00} - {8'h00, frac};
        down_prod = {inv, 8'h00} - {8'h00, inv};
        up        = up_prod[15:8];
        down      = down_prod[15:8];
        red       = '0;
        green     = '0;
        blue      = '0;
        unique case (seg)
            SEG_BLUE: begin
                blue = up;
            end
            SEG_CYAN: begin
                green = up;
                blue  = '1;
            end
            SEG_YELLOW: begin
                red   = up;
                green = '1;
                blue  = down;
            end
            SEG_RED: begin
                red   = '1;
                green = down;
            end
            default: begin
                red = '0;
            end
        endcase
    end

    // Output register.
    logic [COLOUR_W-1:0] r_o_colour;
    logic [ADDR_W-1:0]   r_o_addr;
    logic                r_o_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= sc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_colour <= {red, green, blue};
            r_o_addr   <= sc_tag[TAG_W-1:1];
            r_o_err    <= sc_tag[0];
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = OUT_DATA_W'({r_o_addr, r_o_colour});
    assign m_axis_tuser  = r_o_err;

endmodule

@@ sim/displacement_heatmap_pixel_tb.sv @@
module displacement_heatmap_pixel_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dhp_pkg::*;

    localparam int SAMPLE_W  = 24;
    localparam int IN_DATA_W = ((2 * SAMPLE_W + 2 * COORD_W + 7) / 8) * 8;
    localparam int END_WAIT  = SAMPLE_W + 20;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct {
        logic signed [SAMPLE_W-1:0] horiz;
        logic signed [SAMPLE_W-1:0] vert;
        logic [COORD_W-1:0]         col;
        logic [COORD_W-1:0]         row;
    } t_sample;

    typedef struct {
        logic [COLOUR_W-1:0] colour;
        logic [ADDR_W-1:0]   address;
        logic                coord_err;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Register copies used for prediction.
    logic [FS_W-1:0]      full_scale_reg = RST_FULL_SCALE;
    logic [DIM_REG_W-1:0] frame_width_reg = RST_FRAME_WIDTH;
    logic [DIM_REG_W-1:0] frame_height_reg = RST_FRAME_HEIGHT;

    t_sample pending_samples[$];
    t_pixel  pixel_expected[$];
    t_sample held_sample;
    logic    sample_held = 1'b0;
    logic    sample_taken = 1'b0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned error_count = 0;
    int unsigned samples_sent = 0;
    int unsigned pixels_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned off_frame_pixels = 0;
    int unsigned saturated_pixels = 0;

    always #10 i_clk = ~i_clk;

    displacement_heatmap_pixel #(
        .SAMPLE_BITS(SAMPLE_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    function automatic int unsigned eff_dim(logic [DIM_REG_W-1:0] dim);
        return (dim > MAX_DIM) ? MAX_DIM : dim;
    endfunction

    // Bitwise search for the largest root whose square does not exceed x.
    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Four-segment heat scale: black, blue, cyan, yellow, red.
    function automatic logic [COLOUR_W-1:0] heat_rgb(int unsigned level);
        t_seg seg;
        int unsigned frac;
        int unsigned up;
        int unsigned down;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        seg = ((level >> SEG_LSB) > 3) ? SEG_RED : t_seg'(level >> SEG_LSB);
        frac = level - SEG_SPAN * int'(seg);
        up = (255 * frac) >> SEG_LSB;
        down = (255 * (SEG_SPAN - frac)) >> SEG_LSB;
        red = '0;
        green = '0;
        blue = '0;
        case (seg)
            SEG_BLUE: begin
                blue = CHAN_W'(up);
            end
            SEG_CYAN: begin
                green = CHAN_W'(up);
                blue = '1;
            end
            SEG_YELLOW: begin
                red = CHAN_W'(up);
                green = '1;
                blue = CHAN_W'(down);
            end
            default: begin
                red = '1;
                green = CHAN_W'(down);
            end
        endcase
        return {red, green, blue};
    endfunction

    // Expected pixel for one sample under the current register copies.
    function automatic t_pixel predict_pixel(logic signed [SAMPLE_W-1:0] horiz,
                                             logic signed [SAMPLE_W-1:0] vert,
                                             logic [COORD_W-1:0] col,
                                             logic [COORD_W-1:0] row);
        longint hx;
        longint vx;
        longint unsigned mag;
        longint unsigned scale;
        longint unsigned level;
        int unsigned w_eff;
        int unsigned h_eff;
        t_pixel px;
        hx = longint'(horiz);
        vx = longint'(vert);
        if (hx < 0) begin
            hx = -hx;
        end
        if (vx < 0) begin
            vx = -vx;
        end
        mag = floor_sqrt(hx * hx + vx * vx);
        // A zero full scale behaves as one.
        scale = (full_scale_reg == 0) ? 64'd1 : 64'(full_scale_reg);
        level = (mag * LEVEL_TOP) / scale;
        if (level > LEVEL_TOP) begin
            level = LEVEL_TOP;
        end
        px.colour = heat_rgb(int'(level));
        w_eff = eff_dim(frame_width_reg);
        h_eff = eff_dim(frame_height_reg);
        px.coord_err = (col >= w_eff) || (row >= h_eff);
        px.address = px.coord_err ? '0 : ADDR_W'((h_eff - row - 1) * w_eff + col);
        return px;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_sample(t_sample s);
        return IN_DATA_W'({s.row, s.col, s.vert, s.horiz});
    endfunction

    // Driver: presents queued samples and toggles the result-side ready.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (sample_taken) begin
                sample_taken = 1'b0;
                sample_held = 1'b0;
            end
            if (!sample_held && pending_samples.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                held_sample = pending_samples.pop_front();
                sample_held = 1'b1;
            end
            s_axis_tvalid <= sample_held;
            if (sample_held) begin
                s_axis_tdata <= pack_sample(held_sample);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: tracks register writes, predicts accepted samples, checks pixels.
    always @(posedge i_clk) begin
        t_pixel want;
        t_pixel got;
        if (!i_rst_n) begin
            full_scale_reg = RST_FULL_SCALE;
            frame_width_reg = RST_FRAME_WIDTH;
            frame_height_reg = RST_FRAME_HEIGHT;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                case (i_cfg_index)
                    CFG_FULL_SCALE:   full_scale_reg = i_cfg_data[FS_W-1:0];
                    CFG_FRAME_WIDTH:  frame_width_reg = i_cfg_data[DIM_REG_W-1:0];
                    CFG_FRAME_HEIGHT: frame_height_reg = i_cfg_data[DIM_REG_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sample_taken = 1'b1;
                samples_sent++;
                pixel_expected.push_back(predict_pixel(
                    s_axis_tdata[SAMPLE_W-1:0],
                    s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W],
                    s_axis_tdata[2*SAMPLE_W +: COORD_W],
                    s_axis_tdata[2*SAMPLE_W+COORD_W +: COORD_W]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.colour = m_axis_tdata[COLOUR_W-1:0];
                got.address = m_axis_tdata[COLOUR_W +: ADDR_W];
                got.coord_err = m_axis_tuser;
                if (pixel_expected.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected pixel, expected none, actual colour=%h address=%h err=%b",
                             $time, got.colour, got.address, got.coord_err);
                end else begin
                    want = pixel_expected.pop_front();
                    pixels_checked++;
                    if (want.coord_err) begin
                        off_frame_pixels++;
                    end
                    if (want.colour == {{CHAN_W{1'b1}}, {2*CHAN_W{1'b0}}}) begin
                        saturated_pixels++;
                    end
                    if (got.colour !== want.colour || got.address !== want.address ||
                        got.coord_err !== want.coord_err) begin
                        error_count++;
                        $display("%0t: pixel mismatch expected colour=%h address=%h err=%b",
                                 $time, want.colour, want.address, want.coord_err);
                        $display("%0t:                actual colour=%h address=%h err=%b",
                                 $time, got.colour, got.address, got.coord_err);
                    end
                end
            end
        end
    end

    task automatic add_sample(int horiz, int vert, int col, int row);
        t_sample s;
        s.horiz = SAMPLE_W'(horiz);
        s.vert = SAMPLE_W'(vert);
        s.col = COORD_W'(col);
        s.row = COORD_W'(row);
        pending_samples.push_back(s);
    endtask

    // Holds valid across back-to-back writes; the caller lowers it afterwards.
    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sender stays quiet until every pending sample has come back as a pixel.
    task automatic wait_idle();
        while (pending_samples.size() != 0 || sample_held || pixel_expected.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] extreme_disp();
        case ($urandom_range(0, 4))
            0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
            1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return SAMPLE_W'(1);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_dim();
        case ($urandom_range(0, 7))
            0: return CFG_DATA_W'(1);
            1: return CFG_DATA_W'(MAX_DIM);
            2: return CFG_DATA_W'($urandom);
            3: return CFG_DATA_W'($urandom_range(1, 32));
            default: return CFG_DATA_W'($urandom_range(1, MAX_DIM));
        endcase
    endfunction

    task automatic pick_random_setting();
        logic [CFG_DATA_W-1:0] fs;
        case ($urandom_range(0, 5))
            0: fs = CFG_DATA_W'(1);
            1: fs = '1;
            2: fs = RST_FULL_SCALE;
            3: fs = CFG_DATA_W'($urandom_range(2, 255));
            4: fs = CFG_DATA_W'($urandom_range(256, 4096));
            default: fs = CFG_DATA_W'($urandom_range(1, (1 << FS_W) - 1));
        endcase
        write_register(CFG_FULL_SCALE, fs);
        write_register(CFG_FRAME_WIDTH, random_dim());
        write_register(CFG_FRAME_HEIGHT, random_dim());
        end_writes();
    endtask

    // Mostly displacements scaled around full scale, so every color segment is hit.
    task automatic queue_random_batch(int count);
        t_sample s;
        int unsigned lim;
        int unsigned w_eff;
        int unsigned h_eff;
        w_eff = eff_dim(frame_width_reg);
        h_eff = eff_dim(frame_height_reg);
        lim = (full_scale_reg == 0) ? 1 : full_scale_reg;
        lim = lim + lim / 4;
        if (lim > (1 << (SAMPLE_W - 1)) - 1) begin
            lim = (1 << (SAMPLE_W - 1)) - 1;
        end
        repeat (count) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    s.horiz = SAMPLE_W'($urandom);
                    s.vert = SAMPLE_W'($urandom);
                end
                2: begin
                    s.horiz = extreme_disp();
                    s.vert = extreme_disp();
                end
                default: begin
                    s.horiz = SAMPLE_W'(int'($urandom_range(0, 2 * lim)) - int'(lim));
                    s.vert = SAMPLE_W'(int'($urandom_range(0, 2 * lim)) - int'(lim));
                end
            endcase
            if ($urandom_range(0, 4) != 0 && w_eff > 0 && h_eff > 0) begin
                s.col = COORD_W'($urandom_range(0, w_eff - 1));
                s.row = COORD_W'($urandom_range(0, h_eff - 1));
            end else begin
                s.col = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
                s.row = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
            end
            pending_samples.push_back(s);
        end
    endtask

    initial begin
        int levels[11] = '{1, 255, 256, 257, 511, 512, 767, 768, 1023, 1024, 1025};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 65;

        // Reset settings: segment edges (one level per 64 of magnitude) and field extremes.
        add_sample(0, 0, 0, 0);
        foreach (levels[k]) begin
            add_sample((k % 2 == 0) ? levels[k] * 64 : -levels[k] * 64, 0, k, k);
        end
        add_sample(-3000, 4000, 512, 511);
        add_sample(8388607, 8388607, 1023, 1023);
        add_sample(-8388608, -8388608, 1023, 0);
        add_sample(-8388608, 0, 0, 1023);
        add_sample(0, -1, 1, 2);
        wait_idle();

        // Zero full scale, oversized frame, high data bits dropped, unmapped index.
        write_register(CFG_FULL_SCALE, 0);
        write_register(CFG_FRAME_WIDTH, 2047);
        write_register(CFG_FRAME_HEIGHT, 24'hABC403);
        write_register(CFG_UNMAPPED, 24'h000123);
        end_writes();
        add_sample(0, 0, 0, 0);
        add_sample(1, 0, 1023, 1023);
        add_sample(0, -1, 5, 1000);
        wait_idle();

        // Zero frame width: every coordinate is off the frame.
        write_register(CFG_FRAME_WIDTH, 0);
        write_register(CFG_FRAME_HEIGHT, 5);
        end_writes();
        add_sample(100, 100, 0, 0);
        add_sample(-100, 7, 3, 4);
        wait_idle();

        // Single-pixel frame at the largest full scale.
        write_register(CFG_FULL_SCALE, 24'hFFFFFF);
        write_register(CFG_FRAME_WIDTH, 1);
        write_register(CFG_FRAME_HEIGHT, 1);
        end_writes();
        add_sample(8388607, -8388608, 0, 0);
        add_sample(0, 0, 1, 0);
        add_sample(0, 0, 0, 1);
        wait_idle();

        // Random part over three handshake pressure phases.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 7;
                    recv_idle_pct = 65;
                end
                1: begin
                    send_idle_pct = 65;
                    recv_idle_pct = 7;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (4) begin
                pick_random_setting();
                queue_random_batch(80);
                wait_idle();
            end
        end

        repeat (END_WAIT) @(negedge i_clk);
        if (pixel_expected.size() != 0) begin
            error_count++;
        end
        $display("Sent %0d samples over %0d register writes; checked %0d pixels.",
                 samples_sent, reg_writes, pixels_checked);
        $display("Off-frame pixels: %0d, fully saturated pixels: %0d.",
                 off_frame_pixels, saturated_pixels);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("Timed out with %0d pixels outstanding.", pixel_expected.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/dhp_pkg.sv
rtl/dhp_isqrt.sv
rtl/dhp_scale.sv
rtl/displacement_heatmap_pixel.sv
sim/displacement_heatmap_pixel_tb.sv
